// ===== sv/morse_key_letter_decoder_defines.svh =====
// Assertion macros for the Morse key letter decoder.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MORSE_KEY_LETTER_DECODER_DEFINES_SVH
`define MORSE_KEY_LETTER_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled in reset
`define MKLD_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mkld check failed");
// next-cycle implication, disabled in reset
`define MKLD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mkld check failed");
`else
`define MKLD_ASSERT(label, clk, rst_n, ante, cons)
`define MKLD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/mkld_pkg.sv =====
// Shared types, constants and letter tables for the Morse key letter decoder.
// No dependencies.
`default_nettype none

package mkld_pkg;

  localparam int MaxSymbols = 5;
  localparam int CountWidth = 11;
  localparam int SymCntW    = 3;   // holds 0..MaxSymbols
  localparam int ThrW       = 10;
  localparam int CfgIdxW    = 2;
  localparam int KindW      = 2;
  localparam int CodeW      = 5;
  localparam int NumLetters = 26;

  localparam logic [CodeW-1:0]      ErrorCode = CodeW'(26);
  localparam logic [CountWidth-1:0] CountMax  = '1;

  typedef enum logic [KindW-1:0] {
    EvLetter  = 2'd0,
    EvTooMany = 2'd1,
    EvTooLong = 2'd2,
    EvNoMatch = 2'd3
  } event_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDash  = 2'd0,
    CfgPress = 2'd1,
    CfgGap   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ThrW-1:0] dash_thr;
    logic [ThrW-1:0] press_limit;
    logic [ThrW-1:0] gap_thr;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    event_kind_e              kind;
    logic [CodeW-1:0]         code;
  } event_t;

  typedef struct packed {
    logic             hit;
    logic [CodeW-1:0] index;
  } match_t;

  // symbol count per letter A..Z
  localparam logic [SymCntW-1:0] LetterLen [NumLetters] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // pattern per letter, first symbol at bit 0, dash = 1
  localparam logic [MaxSymbols-1:0] LetterBits [NumLetters] = '{
    5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14, 5'd5, 5'd2, 5'd3,
    5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3
  };

endpackage

`default_nettype wire

// ===== sv/mkld_cfg_regs.sv =====
// Threshold registers of the Morse key letter decoder, written through a plain port.
// Depends on mkld_pkg.
`default_nettype none

module mkld_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mkld_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [mkld_pkg::ThrW-1:0]     cfg_data_i,
  output mkld_pkg::cfg_t                     cfg_o
);

  mkld_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (mkld_pkg::cfg_idx_e'(cfg_index_i))
        mkld_pkg::CfgDash:  cfg_d.dash_thr    = cfg_data_i;
        mkld_pkg::CfgPress: cfg_d.press_limit = cfg_data_i;
        mkld_pkg::CfgGap:   cfg_d.gap_thr     = cfg_data_i;
        default:            cfg_d = cfg_q;   // unmapped index ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dash_thr    <= mkld_pkg::ThrW'(250);
      cfg_q.press_limit <= mkld_pkg::ThrW'(700);
      cfg_q.gap_thr     <= mkld_pkg::ThrW'(400);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/mkld_letter_match.sv =====
// Parallel match of a held symbol pattern against the 26 letter codes.
// Depends on mkld_pkg.
`default_nettype none

module mkld_letter_match (
  input  wire logic [mkld_pkg::SymCntW-1:0]    sym_count_i,
  input  wire logic [mkld_pkg::MaxSymbols-1:0] sym_bits_i,
  output mkld_pkg::match_t                     match_o
);

  logic [mkld_pkg::NumLetters-1:0] hit;
  logic [mkld_pkg::CodeW-1:0]      index;

  always_comb begin
    for (int i = 0; i < mkld_pkg::NumLetters; i++) begin
      hit[i] = (mkld_pkg::LetterLen[i] == sym_count_i) &&
               (mkld_pkg::LetterBits[i] == sym_bits_i);
    end
  end

  // letter codes are unique, so at most one hit: OR the indices together
  always_comb begin
    index = '0;
    for (int i = 0; i < mkld_pkg::NumLetters; i++) begin
      if (hit[i]) begin
        index = index | mkld_pkg::CodeW'(i);
      end
    end
  end

  assign match_o.hit   = |hit;
  assign match_o.index = index;

endmodule

`default_nettype wire

// ===== sv/mkld_core.sv =====
// Decode state of the Morse key letter decoder: press/gap timing and symbol capture.
// Depends on mkld_pkg and mkld_letter_match.
`default_nettype none

module mkld_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic           level_i,
  input  wire mkld_pkg::cfg_t cfg_i,
  output mkld_pkg::event_t    event_o
);

  logic                              active_q, active_d;
  logic                              key_down_q, key_down_d;
  logic [mkld_pkg::CountWidth-1:0]   count_q, count_d;
  logic [mkld_pkg::SymCntW-1:0]      sym_cnt_q, sym_cnt_d;
  logic [mkld_pkg::MaxSymbols-1:0]   sym_bits_q, sym_bits_d;
  logic [mkld_pkg::CountWidth-1:0]   count_inc;
  logic [mkld_pkg::CountWidth-1:0]   dash_thr, press_limit, gap_thr;
  mkld_pkg::match_t                  match;
  mkld_pkg::event_t                  evt;

  mkld_letter_match u_match (
    .sym_count_i (sym_cnt_q),
    .sym_bits_i  (sym_bits_q),
    .match_o     (match)
  );

  assign count_inc   = (count_q == mkld_pkg::CountMax) ? count_q
                                                       : count_q + 1'b1;
  assign dash_thr    = mkld_pkg::CountWidth'(cfg_i.dash_thr);
  assign press_limit = mkld_pkg::CountWidth'(cfg_i.press_limit);
  assign gap_thr     = mkld_pkg::CountWidth'(cfg_i.gap_thr);

  always_comb begin
    active_d   = active_q;
    key_down_d = key_down_q;
    count_d    = count_q;
    sym_cnt_d  = sym_cnt_q;
    sym_bits_d = sym_bits_q;
    evt.valid  = 1'b0;
    evt.kind   = mkld_pkg::EvLetter;
    evt.code   = mkld_pkg::ErrorCode;

    if (!active_q) begin
      if (level_i) begin
        active_d   = 1'b1;
        key_down_d = 1'b1;
        count_d    = '0;
        sym_cnt_d  = '0;
        sym_bits_d = '0;
      end
    end else if (level_i) begin
      key_down_d = 1'b1;
      count_d    = key_down_q ? count_inc : '0;
    end else if (key_down_q) begin
      // release: overflow check first, then press limit, then dot/dash
      key_down_d = 1'b0;
      count_d    = '0;
      if (sym_cnt_q >= mkld_pkg::SymCntW'(mkld_pkg::MaxSymbols)) begin
        evt.valid = 1'b1;
        evt.kind  = mkld_pkg::EvTooMany;
      end else if (count_q > press_limit) begin
        evt.valid = 1'b1;
        evt.kind  = mkld_pkg::EvTooLong;
      end else begin
        if (count_q > dash_thr) begin
          sym_bits_d = sym_bits_q | (mkld_pkg::MaxSymbols'(1) << sym_cnt_q);
        end
        sym_cnt_d = sym_cnt_q + 1'b1;
      end
    end else begin
      count_d = count_inc;
      if (count_inc > gap_thr) begin
        evt.valid = 1'b1;
        if (match.hit) begin
          evt.kind = mkld_pkg::EvLetter;
          evt.code = match.index;
        end else begin
          evt.kind = mkld_pkg::EvNoMatch;
        end
      end
    end

    // any report returns to idle
    if (evt.valid) begin
      active_d   = 1'b0;
      key_down_d = 1'b0;
      count_d    = '0;
      sym_cnt_d  = '0;
      sym_bits_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      key_down_q <= 1'b0;
      count_q    <= '0;
      sym_cnt_q  <= '0;
      sym_bits_q <= '0;
    end else if (step_i) begin
      active_q   <= active_d;
      key_down_q <= key_down_d;
      count_q    <= count_d;
      sym_cnt_q  <= sym_cnt_d;
      sym_bits_q <= sym_bits_d;
    end
  end

  assign event_o = evt;

endmodule

`default_nettype wire

// ===== sv/morse_key_letter_decoder.sv =====
// Morse key letter decoder: one key level per tick in, letter or error reports out.
//
// Input channel: in_valid_i / in_stall_o carry button_level_i, one sample per
// tick; a transfer happens on a rising edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry event_kind_o and
// display_code_o; most ticks produce no report.
// Throughput: one sample per cycle while the output is not stalled. A sample is
// registered on transfer, evaluated against the decode state from the input
// register, and its report, if any, is registered in the result register.
// The state update and letter match sit between the input register and the
// result register, so the per-sample path is one counter, one compare chain
// and a 26-way pattern compare.
// Stall: while a report waits on a stalled output, the sample in the input
// register waits too and in_stall_o goes high; one more sample can be
// taken as the waiting report is drained.
// Reset: thresholds return to 250/700/400 ticks and the decoder goes idle.
// Thresholds are written via cfg_we_i/cfg_index_i/cfg_data_i; the user writes them
// only while idle (not enforced by the block); unmapped-index writes are dropped.
// Depends on mkld_pkg, mkld_cfg_regs, mkld_core and the defines header.
`default_nettype none

`include "morse_key_letter_decoder_defines.svh"

module morse_key_letter_decoder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output wire logic                         in_stall_o,
  input  wire logic                         button_level_i,
  output wire logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output wire logic [mkld_pkg::KindW-1:0]   event_kind_o,
  output wire logic [mkld_pkg::CodeW-1:0]   display_code_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [mkld_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [mkld_pkg::ThrW-1:0]    cfg_data_i
);

  logic                        s1_valid_q;
  logic                        level_q;
  logic                        out_valid_q;
  mkld_pkg::event_kind_e       kind_q;
  logic [mkld_pkg::CodeW-1:0]  code_q;
  logic                        out_free;
  logic                        step;
  logic                        in_xfer;
  mkld_pkg::cfg_t              cfg;
  mkld_pkg::event_t            evt;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  mkld_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mkld_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .level_i (level_q),
    .cfg_i   (cfg),
    .event_o (evt)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      level_q <= button_level_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && evt.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && evt.valid) begin
      kind_q <= evt.kind;
      code_q <= evt.code;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign display_code_o = code_q;

  `MKLD_ASSERT(a_code_matches_kind, clk_i, rst_ni, out_valid_o,
    ((event_kind_o == mkld_pkg::EvLetter) == (display_code_o != mkld_pkg::ErrorCode)))
  `MKLD_ASSERT(a_stall_only_on_held_report, clk_i, rst_ni, in_stall_o,
    (out_valid_o && out_stall_i))
  `MKLD_ASSERT_NXT(a_no_report_from_nothing, clk_i, rst_ni,
    (!out_valid_o && !s1_valid_q), !out_valid_o)

endmodule

`default_nettype wire
